[hdl/led_matrix_text_scroller_assert.svh]
// Assertion macros shared by the scroller RTL.
`ifndef LED_MATRIX_TEXT_SCROLLER_ASSERT_SVH
`define LED_MATRIX_TEXT_SCROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lmts_pkg.sv]
// Package with the item kinds, character codes and font table of the text scroller.
`timescale 1ns / 1ps

package lmts_pkg;

  localparam int MSG_DEPTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  localparam logic [7:0] CHAR_A     = 8'd65;
  localparam logic [7:0] CHAR_Z     = 8'd90;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic [2:0] GAP_MAX = 3'd5;

  localparam logic [1:0] WRAP_NONE = 2'd0;
  localparam logic [1:0] WRAP_SEEN = 2'd1;
  localparam logic [1:0] WRAP_GAP  = 2'd2;

  localparam int NUM_LETTERS = 26;

  // One entry per letter, row 0 in the top byte, MSB is the leftmost column.
  localparam logic [63:0] FONT_ROM [NUM_LETTERS] = '{
    64'h18244242_7e424242, 64'h7c42427c_4242427c, 64'h3c424040_4040423c,
    64'h78444242_42424478, 64'h7e40407e_4040407e, 64'h7e40407e_40404040,
    64'h38444040_4e444438, 64'h4242427e_42424242, 64'h7e181818_1818187e,
    64'h7e080808_08084830, 64'h42444870_70484442, 64'h60606060_6060607e,
    64'h42665a5a_42424242, 64'h4262727a_5e4e4642, 64'h3c424242_4242423c,
    64'h7c424242_7c404040, 64'h18244242_424a241a, 64'h78444478_70484442,
    64'h3c424030_1806423c, 64'h7e7e1818_18181818, 64'h42424242_4242423c,
    64'h42424242_42663c18, 64'h42424242_5a5a6642, 64'h42662418_18246642,
    64'h42424224_18181818, 64'h7e020408_1020407e
  };

  function automatic logic is_letter(input logic [7:0] code);
    return (code >= CHAR_A) && (code <= CHAR_Z);
  endfunction

  // Glyph of a character; anything that is not a capital letter is blank.
  function automatic logic [63:0] glyph_of(input logic [7:0] code);
    logic [7:0] idx;
    idx = code - CHAR_A;
    return is_letter(code) ? FONT_ROM[idx[4:0]] : 64'd0;
  endfunction

endpackage

[hdl/led_matrix_text_scroller.sv]
// Top level of the 8x8 LED matrix text scroller.
`timescale 1ns / 1ps
// Usage:
// Items arrive on the in_ stream. in_tuser carries the kind: write a message
// character (in_tdata holds position and code), restart the scroll, scroll
// tick, or no operation. Every item yields exactly one result item on the
// out_ stream: the eight rows of the current frame, row 0 in the low byte.
// The cfg_ port sets the message length; write it only while the block is idle.
// A write or no-op goes from idle straight to the done state; a restart passes
// through the reset states S_RST0 and S_RST1, and a tick through the tick state,
// followed by the search state when the next frame has run dry. The search reads
// up to length message characters, one per cycle, through the single read port
// of the message store and tests each with one shared letter comparator.
// One item is processed at a time; in_tready is high only in the idle state.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a further result then waits until that register
// is emptied. Reset (rst_n low at a clock edge) blanks both frames, clears
// the scroll position, wrap and gap state and the length, and empties the
// output register. Message store contents are undefined until written.

module led_matrix_text_scroller #(
  parameter int MSG_DEPTH = lmts_pkg::MSG_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] char_position, [12:5] char_code, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // row_0 [7:0], row_1 [15:8], ... row_7 [63:56]
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data // message_length
);

`include "led_matrix_text_scroller_assert.svh"

  localparam int AW = $clog2(MSG_DEPTH);
  localparam int LW = $clog2(MSG_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RST0 = 6'b000010,
    S_RST1 = 6'b000100,
    S_TICK = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  logic [63:0]    out_data_r, out_data_nxt;
  logic [5:0]     msg_len_r;
  logic [7:0]     cur_frm_r [8];
  logic [7:0]     cur_frm_nxt [8];
  logic [7:0]     nxt_frm_r [8];
  logic [7:0]     nxt_frm_nxt [8];
  logic [AW-1:0]  rp_r, rp_nxt;
  logic [1:0]     wp_r, wp_nxt;
  logic [2:0]     gap_r, gap_nxt;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic           wrapped_r, wrapped_nxt;

  // Message store: one write port, one registered read port.
  logic [7:0]     mem [MSG_DEPTH];
  logic [7:0]     rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;

  logic                 accept;
  lmts_pkg::kind_t      in_kind;
  logic [4:0]           in_pos;
  logic [7:0]           in_code;
  logic [LW-1:0]        len_eff;
  logic [AW-1:0]        rp_back2;
  logic [2:0]           gap_t;
  logic                 hold;
  logic                 empty;
  logic [LW-1:0]        pinc;
  logic [AW-1:0]        newp;
  logic [1:0]           wp_t;
  logic [63:0]          glyph;

  assign in_kind = lmts_pkg::kind_t'(in_tuser[1:0]);
  assign in_pos  = in_tdata[4:0];
  assign in_code = in_tdata[12:5];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Lengths above the store depth act as the full store.
  assign len_eff = (32'(msg_len_r) > 32'(MSG_DEPTH)) ? LW'(MSG_DEPTH) : LW'(msg_len_r);

  // The gap check looks at the character two places behind the read position.
  assign rp_back2 = (rp_r > AW'(1)) ? (rp_r - AW'(2)) : '0;

  assign mem_we = accept && (in_kind == lmts_pkg::KIND_WRITE) &&
                  (32'(in_pos) < 32'(MSG_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_pos)] <= in_code;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    cur_frm_nxt    = cur_frm_r;
    nxt_frm_nxt    = nxt_frm_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    gap_nxt        = gap_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    wrapped_nxt    = wrapped_r;
    rd_addr        = '0;
    gap_t          = gap_r;
    hold           = 1'b0;
    empty          = 1'b1;
    pinc           = LW'(pos_r) + LW'(1);
    newp           = '0;
    wp_t           = wp_r;
    glyph          = lmts_pkg::glyph_of(rd_data_r);

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            lmts_pkg::KIND_RESTART: begin
              rd_addr   = '0;
              state_nxt = S_RST0;
            end
            lmts_pkg::KIND_TICK: begin
              rd_addr   = rp_back2;
              state_nxt = S_TICK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RST0: begin
        // Character 0 goes straight into the visible frame.
        wp_nxt  = lmts_pkg::WRAP_NONE;
        gap_nxt = '0;
        rp_nxt  = '0;
        for (int r = 0; r < 8; r++) begin
          cur_frm_nxt[r] = '0;
          nxt_frm_nxt[r] = '0;
          if (len_eff != '0) begin
            cur_frm_nxt[r] = glyph[(7 - r) * 8 +: 8];
          end
        end
        if (len_eff > LW'(1)) begin
          rp_nxt = AW'(1);
        end
        rd_addr   = AW'(1);
        state_nxt = S_RST1;
      end

      S_RST1: begin
        // Character 1 waits in the next frame, already one column in.
        if (len_eff > LW'(1)) begin
          for (int r = 0; r < 8; r++) begin
            nxt_frm_nxt[r] = {glyph[(7 - r) * 8 +: 7], 1'b0};
          end
          rp_nxt = (LW'(2) >= len_eff) ? '0 : AW'(2);
        end
        state_nxt = S_DONE;
      end

      S_TICK: begin
        // A space or a fresh wrap two characters back opens a gap of four
        // columns during which the next frame is held.
        if ((rd_data_r == lmts_pkg::CHAR_SPACE) || (wp_r == lmts_pkg::WRAP_GAP)) begin
          gap_t = (gap_r < lmts_pkg::GAP_MAX) ? (gap_r + 3'd1) : lmts_pkg::GAP_MAX;
        end
        hold = (gap_t != '0) && (gap_t < lmts_pkg::GAP_MAX);
        for (int r = 0; r < 8; r++) begin
          cur_frm_nxt[r] = {cur_frm_r[r][6:0], hold ? 1'b0 : nxt_frm_r[r][7]};
          if (!hold) begin
            nxt_frm_nxt[r] = {nxt_frm_r[r][6:0], 1'b0};
          end
          if (nxt_frm_nxt[r] != '0) begin
            empty = 1'b0;
          end
        end
        gap_nxt = gap_t;
        if (!empty || (len_eff == '0)) begin
          state_nxt = S_DONE;
        end else begin
          // Next frame ran dry: search the store for the following letter.
          gap_nxt = '0;
          cnt_nxt = '0;
          if (LW'(rp_r) >= len_eff) begin
            pos_nxt     = '0;
            wrapped_nxt = 1'b1;
          end else begin
            pos_nxt     = rp_r;
            wrapped_nxt = 1'b0;
          end
          rd_addr   = pos_nxt;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (lmts_pkg::is_letter(rd_data_r)) begin
          for (int r = 0; r < 8; r++) begin
            nxt_frm_nxt[r] = glyph[(7 - r) * 8 +: 8];
          end
          wp_t = wrapped_r ? lmts_pkg::WRAP_SEEN : wp_r;
          if (pinc >= len_eff) begin
            wp_t = lmts_pkg::WRAP_SEEN;
            newp = '0;
          end else begin
            newp = AW'(pinc);
          end
          if ((newp == AW'(1)) && (wp_t == lmts_pkg::WRAP_SEEN)) begin
            wp_t = lmts_pkg::WRAP_GAP;
          end else if ((newp != AW'(1)) && (wp_t == lmts_pkg::WRAP_GAP)) begin
            wp_t = lmts_pkg::WRAP_NONE;
          end
          rp_nxt    = newp;
          wp_nxt    = wp_t;
          state_nxt = S_DONE;
        end else if ((cnt_r + LW'(1)) == len_eff) begin
          // Whole message looked at and no letter in it.
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
          if (pinc >= len_eff) begin
            pos_nxt     = '0;
            wrapped_nxt = 1'b1;
          end else begin
            pos_nxt = AW'(pinc);
          end
          rd_addr = pos_nxt;
        end
      end

      S_DONE: begin
        // The frame waits here while the previous result is still unread.
        if (!out_tvalid_r || out_tready) begin
          for (int r = 0; r < 8; r++) begin
            out_data_nxt[r * 8 +: 8] = cur_frm_r[r];
          end
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      msg_len_r    <= '0;
      rp_r         <= '0;
      wp_r         <= lmts_pkg::WRAP_NONE;
      gap_r        <= '0;
      for (int r = 0; r < 8; r++) begin
        cur_frm_r[r] <= '0;
        nxt_frm_r[r] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        msg_len_r <= cfg_wr_data;
      end
      rp_r      <= rp_nxt;
      wp_r      <= wp_nxt;
      gap_r     <= gap_nxt;
      cur_frm_r <= cur_frm_nxt;
      nxt_frm_r <= nxt_frm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    wrapped_r  <= wrapped_nxt;
  end

  `LMTS_ASSERT_NOW(a_ready_only_idle, in_tready, state_r == S_IDLE, "ready outside idle")
  `LMTS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "item accepted but idle")
  `LMTS_ASSERT_NEXT(a_done_gives_result, state_r == S_DONE, out_tvalid_r, "no result after item")
  `LMTS_ASSERT_NOW(a_scan_bounded, state_r == S_SCAN, cnt_r < len_eff, "search ran past length")
  `LMTS_ASSERT_NOW(a_gap_saturates, 1'b1, gap_r <= lmts_pkg::GAP_MAX, "gap count above limit")

endmodule

[tb/led_matrix_text_scroller_test.sv]
// Self-checking testbench for the 8x8 LED matrix text scroller.
`timescale 1ns / 1ps

module led_matrix_text_scroller_test;

  // The block is built with its default store depth.
  localparam int STORE_DEPTH = lmts_pkg::MSG_DEPTH_DEFAULT;

  // A refill walks at most the whole store, one character per cycle, so the
  // margin below covers the slowest item with room to spare.
  localparam int LATENCY_MARGIN = 40;

  // The slowest correct run is about 2000 items, each slowed by a sender gap,
  // a full-store refill and a receiver stall. The limit is several times what
  // such a run needs.
  localparam int CYCLE_LIMIT = 1000000;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 190;

  // Lengths of the first random phases: full store, empty, one and two characters,
  // the register's top value, four, one just past the store depth, and three.
  localparam int PHASE_LENGTHS [8] = '{32, 0, 1, 2, 63, 4, 33, 3};

  // Font of the 26 capital letters, row 0 in the top byte, MSB leftmost.
  localparam logic [63:0] LETTER_FONT [26] = '{
    64'h18244242_7e424242, 64'h7c42427c_4242427c, 64'h3c424040_4040423c,
    64'h78444242_42424478, 64'h7e40407e_4040407e, 64'h7e40407e_40404040,
    64'h38444040_4e444438, 64'h4242427e_42424242, 64'h7e181818_1818187e,
    64'h7e080808_08084830, 64'h42444870_70484442, 64'h60606060_6060607e,
    64'h42665a5a_42424242, 64'h4262727a_5e4e4642, 64'h3c424242_4242423c,
    64'h7c424242_7c404040, 64'h18244242_424a241a, 64'h78444478_70484442,
    64'h3c424030_1806423c, 64'h7e7e1818_18181818, 64'h42424242_4242423c,
    64'h42424242_42663c18, 64'h42424242_5a5a6642, 64'h42662418_18246642,
    64'h42424224_18181818, 64'h7e020408_1020407e
  };

  // Result packing: row_0 in the low byte up to row_7 in the top byte.
  localparam logic [63:0] ROWS_BLANK   = 64'h0;
  localparam logic [63:0] ROWS_GLYPH_A = 64'h4242427e_42422418;

  // One line of the directed table. A line is either a length register write
  // (is_cfg set) or an item. Where typed is set, rows holds the frame that is
  // known by inspection; every other item is checked against the predictor.
  typedef struct packed {
    logic            is_cfg;
    logic [5:0]      length;
    lmts_pkg::kind_t kind;
    logic [4:0]      pos;
    logic [7:0]      code;
    logic            typed;
    logic [63:0]     rows;
  } step_t;

  localparam int NUM_DIRECTED = 26;

  localparam step_t DIRECTED_STEPS [NUM_DIRECTED] = '{
    // Straight out of reset: length 0, blank frames, every item shows blank.
    '{1'b0, 6'd0, lmts_pkg::KIND_WRITE,   5'd0,  lmts_pkg::CHAR_A,     1'b1, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_NOP,     5'd31, 8'hff,                1'b1, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b1, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_RESTART, 5'd0,  8'h00,                1'b1, ROWS_BLANK},
    // Message "A ZB": the space two places behind the read position opens a gap.
    '{1'b1, 6'd4, lmts_pkg::KIND_NOP,     5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_WRITE,   5'd1,  lmts_pkg::CHAR_SPACE, 1'b1, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_WRITE,   5'd2,  lmts_pkg::CHAR_Z,     1'b1, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_WRITE,   5'd3,  "B",                  1'b1, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_RESTART, 5'd0,  8'h00,                1'b1, ROWS_GLYPH_A},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    // One-character message: restart leaves the next frame blank.
    '{1'b1, 6'd1, lmts_pkg::KIND_NOP,     5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_RESTART, 5'd0,  8'h00,                1'b1, ROWS_GLYPH_A},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b0, ROWS_BLANK},
    // Extreme codes and the last store position; a non-letter shows blank.
    '{1'b0, 6'd0, lmts_pkg::KIND_WRITE,   5'd0,  8'hff,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_WRITE,   5'd31, 8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_RESTART, 5'd0,  8'h00,                1'b1, ROWS_BLANK},
    // A message without any letter: the refill finds nothing to load.
    '{1'b1, 6'd2, lmts_pkg::KIND_NOP,     5'd0,  8'h00,                1'b0, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_RESTART, 5'd0,  8'h00,                1'b1, ROWS_BLANK},
    '{1'b0, 6'd0, lmts_pkg::KIND_TICK,    5'd0,  8'h00,                1'b1, ROWS_BLANK}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;

  // Mirror of the marquee state, updated as items are accepted.
  logic [7:0] store_mirror [STORE_DEPTH];
  logic [7:0] frame_cur [8];
  logic [7:0] frame_next [8];
  int         read_pos   = 0;
  logic [1:0] wrap_state = lmts_pkg::WRAP_NONE;
  int         gap_run    = 0;
  int         msg_len    = 0;

  // Frames still owed by the block, oldest first.
  logic [63:0] expected_frames [$];

  // Random idling on each side; cleared for whole phases to get back-to-back runs.
  logic idle_enable  = 1'b1;
  logic stall_enable = 1'b1;

  int kind_count [4]  = '{0, 0, 0, 0};
  int frames_checked  = 0;
  int mismatch_count  = 0;
  int length_settings = 0;
  int cycle_count     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_matrix_text_scroller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // One row of a character's glyph; anything but a capital letter is blank.
  function automatic logic [7:0] font_row(input logic [7:0] code, input int r);
    logic [63:0] g;
    if (code < lmts_pkg::CHAR_A || code > lmts_pkg::CHAR_Z) return 8'h00;
    g = LETTER_FONT[code - lmts_pkg::CHAR_A];
    return g[63 - 8 * r -: 8];
  endfunction

  // Applies one item to the mirrored state and returns the frame it shows.
  function automatic logic [63:0] advance_marquee(input lmts_pkg::kind_t kind,
                                                  input logic [4:0] pos,
                                                  input logic [7:0] code);
    int          len;
    int          scan;
    int          n;
    int          r;
    logic        wrapped;
    logic        found;
    logic        drained;
    logic [7:0]  behind;
    logic [63:0] rows;
    // Lengths beyond the store depth behave as the full store.
    len = (msg_len > STORE_DEPTH) ? STORE_DEPTH : msg_len;
    case (kind)
      lmts_pkg::KIND_WRITE: begin
        store_mirror[pos] = code;
      end
      lmts_pkg::KIND_RESTART: begin
        read_pos   = 0;
        wrap_state = lmts_pkg::WRAP_NONE;
        gap_run    = 0;
        for (r = 0; r < 8; r++) begin
          frame_cur[r]  = 8'h00;
          frame_next[r] = 8'h00;
        end
        if (len > 0) begin
          for (r = 0; r < 8; r++) frame_cur[r] = font_row(store_mirror[0], r);
          read_pos = (len > 1) ? 1 : 0;
        end
        // The second character starts one column in, already shifted left.
        if (len > 1) begin
          for (r = 0; r < 8; r++) frame_next[r] = font_row(store_mirror[read_pos], r) << 1;
          read_pos++;
          if (read_pos >= len) read_pos = 0;
        end
      end
      lmts_pkg::KIND_TICK: begin
        // A space two characters back, or a fresh wrap, holds the next frame.
        behind = store_mirror[(read_pos > 1) ? read_pos - 2 : 0];
        if (behind == lmts_pkg::CHAR_SPACE || wrap_state == lmts_pkg::WRAP_GAP)
          gap_run = (gap_run < lmts_pkg::GAP_MAX) ? gap_run + 1 : lmts_pkg::GAP_MAX;
        drained = 1'b1;
        for (r = 0; r < 8; r++) begin
          frame_cur[r] = frame_cur[r] << 1;
          if (!(gap_run > 0 && gap_run < lmts_pkg::GAP_MAX)) begin
            frame_cur[r]  = frame_cur[r] | {7'd0, frame_next[r][7]};
            frame_next[r] = frame_next[r] << 1;
          end
          if (frame_next[r] != 8'h00) drained = 1'b0;
        end
        // Refill: look for the next letter, wrapping once around the message.
        if (drained && len > 0) begin
          scan    = read_pos;
          wrapped = 1'b0;
          found   = 1'b0;
          for (n = 0; n < len && !found; n++) begin
            if (scan >= len) begin
              scan    = 0;
              wrapped = 1'b1;
            end
            if (store_mirror[scan] >= lmts_pkg::CHAR_A &&
                store_mirror[scan] <= lmts_pkg::CHAR_Z) found = 1'b1;
            else scan++;
          end
          gap_run = 0;
          if (found) begin
            for (r = 0; r < 8; r++) frame_next[r] = font_row(store_mirror[scan], r);
            if (wrapped) wrap_state = lmts_pkg::WRAP_SEEN;
            scan++;
            if (scan >= len) begin
              wrap_state = lmts_pkg::WRAP_SEEN;
              scan       = 0;
            end
            read_pos = scan;
            if (read_pos == 1 && wrap_state == lmts_pkg::WRAP_SEEN)
              wrap_state = lmts_pkg::WRAP_GAP;
            if (read_pos != 1 && wrap_state == lmts_pkg::WRAP_GAP)
              wrap_state = lmts_pkg::WRAP_NONE;
          end
        end
      end
      default: begin
      end
    endcase
    for (r = 0; r < 8; r++) rows[8 * r +: 8] = frame_cur[r];
    return rows;
  endfunction

  // Message content: mostly letters, a good share of spaces, the rest any code.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 8'($urandom_range(lmts_pkg::CHAR_A, lmts_pkg::CHAR_Z));
    if (roll < 75) return lmts_pkg::CHAR_SPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one item after a random gap, waits for the handshake, and records
  // the frame the block owes for it.
  task automatic push_item(input lmts_pkg::kind_t kind, input logic [4:0] pos,
                           input logic [7:0] code,
                           input logic typed, input logic [63:0] typed_rows);
    int          gap;
    logic [63:0] predicted;
    gap = idle_enable ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, code, pos};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predicted = advance_marquee(kind, pos, code);
    expected_frames.push_back(typed ? typed_rows : predicted);
    kind_count[kind]++;
  endtask

  // Stops offering items until every owed frame has arrived and the block
  // has had time to settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (LATENCY_MARGIN) @(posedge clk);
  endtask

  // The length register is only written while the block is idle.
  task automatic set_length(input int len);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 6'(len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    msg_len = len;
    length_settings++;
  endtask

  // Result side: random back-pressure, then compare each frame row by row.
  initial begin : result_sink
    int          stall;
    int          r;
    logic        bad;
    logic [63:0] want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = stall_enable ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      if (expected_frames.size() == 0) begin
        $display("%0t: frame %h arrived with nothing expected", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        bad  = 1'b0;
        for (r = 0; r < 8; r++) begin
          if (out_tdata[8 * r +: 8] !== want[8 * r +: 8]) begin
            $display("%0t: row_%0d expected %02h actual %02h", $time, r,
                     want[8 * r +: 8], out_tdata[8 * r +: 8]);
            bad = 1'b1;
          end
        end
        if (bad) mismatch_count++;
        frames_checked++;
      end
    end
  end

  // Ends a run that hangs, for example when the block drops a frame.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int    i;
    int    phase;
    int    roll;
    int    r;
    step_t directed_step;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 16'h0000;
    in_tuser    = lmts_pkg::KIND_NOP;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 6'd0;
    for (r = 0; r < 8; r++) begin
      frame_cur[r]  = 8'h00;
      frame_next[r] = 8'h00;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Store entries are written before any item uses them,
    // since the store holds garbage until written.
    for (i = 0; i < NUM_DIRECTED; i++) begin
      directed_step = DIRECTED_STEPS[i];
      if (directed_step.is_cfg)
        set_length(directed_step.length);
      else
        push_item(directed_step.kind, directed_step.pos, directed_step.code,
                  directed_step.typed, directed_step.rows);
    end

    // Fill the whole store so that any length and read position is safe later.
    for (i = 0; i < STORE_DEPTH; i++)
      push_item(lmts_pkg::KIND_WRITE, 5'(i), pick_char(), 1'b0, ROWS_BLANK);

    // Random part: each phase sets a length, restarts the scroll and then runs
    // mostly ticks, with message edits, no-ops and the odd restart mixed in.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      idle_enable  = (phase % 4 != 1);
      stall_enable = (phase % 3 != 2);
      if (phase < 8) set_length(PHASE_LENGTHS[phase]);
      else if (phase == 8) set_length($urandom_range(2, 12));
      else set_length($urandom_range(0, 63));
      push_item(lmts_pkg::KIND_RESTART, 5'($urandom_range(0, 31)),
                8'($urandom_range(0, 255)), 1'b0, ROWS_BLANK);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        // Now and then the sender waits for the result side to catch up fully.
        if (roll == 0) drain_results();
        if (roll < 72)
          push_item(lmts_pkg::KIND_TICK, 5'($urandom_range(0, 31)),
                    8'($urandom_range(0, 255)), 1'b0, ROWS_BLANK);
        else if (roll < 88)
          push_item(lmts_pkg::KIND_WRITE, 5'($urandom_range(0, 31)), pick_char(),
                    1'b0, ROWS_BLANK);
        else if (roll < 93)
          push_item(lmts_pkg::KIND_NOP, 5'($urandom_range(0, 31)),
                    8'($urandom_range(0, 255)), 1'b0, ROWS_BLANK);
        else if (roll < 94)
          push_item(lmts_pkg::KIND_RESTART, 5'($urandom_range(0, 31)),
                    8'($urandom_range(0, 255)), 1'b0, ROWS_BLANK);
        else
          push_item(lmts_pkg::KIND_TICK, 5'($urandom_range(0, 31)),
                    8'($urandom_range(0, 255)), 1'b0, ROWS_BLANK);
      end
    end

    // Wait for the last frames; anything missing runs into the watchdog.
    drain_results();

    $display("Sent %0d writes, %0d restarts, %0d ticks and %0d no-ops.",
             kind_count[lmts_pkg::KIND_WRITE], kind_count[lmts_pkg::KIND_RESTART],
             kind_count[lmts_pkg::KIND_TICK], kind_count[lmts_pkg::KIND_NOP]);
    $display("Compared %0d frames over %0d message lengths; %0d frames were wrong.",
             frames_checked, length_settings, mismatch_count);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
